/* src/beg_pkg.sv */
// Shared types and constants for the binary extended GCD unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package beg_pkg;

  // Operand width, fixed by the beat format.
  localparam int DATA_W  = 32;
  // Coefficient registers carry headroom for the intermediate corrections.
  localparam int COEF_W  = DATA_W + 4;
  // Count of removed common factors of two (at most DATA_W - 1).
  localparam int SHIFT_W = $clog2(DATA_W);

  // Input beat.
  typedef struct packed {
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } operands_t;

  // Result beat.
  typedef struct packed {
    logic signed [DATA_W:0] coefficient_a;
    logic [DATA_W-1:0]      gcd_value;
  } result_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STRIP,
    ST_HALVE_P,
    ST_LOOP
  } state_t;

  // Which result the datapath registers when the controller finishes.
  typedef enum logic [1:0] {
    RES_GCD,
    RES_ZERO_A,
    RES_ZERO_B
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     strip;
    logic     latch_base;
    logic     halve_p;
    logic     halve_q;
    logic     sub;
    logic     finish;
    res_sel_t sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic p_zero;
    logic q_zero;
    logic p_lsb;
    logic q_lsb;
  } status_t;

endpackage

/* src/beg_ctrl.sv */
// Controller state machine of the binary extended GCD unit.
// Depends on beg_pkg for the state, command and status types.
module beg_ctrl
  import beg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  state_t state, state_next;
  logic   done_next;

  // State and result strobe registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    cmd.sel    = RES_GCD;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_STRIP;
        end
      end
      ST_STRIP: begin
        // Zero operands finish at once; otherwise strip shared factors of two.
        if (status.p_zero) begin
          cmd.finish = 1'b1;
          cmd.sel    = RES_ZERO_A;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else if (status.q_zero) begin
          cmd.finish = 1'b1;
          cmd.sel    = RES_ZERO_B;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else if (!status.p_lsb && !status.q_lsb) begin
          cmd.strip = 1'b1;
        end else begin
          cmd.latch_base = 1'b1;
          state_next     = ST_HALVE_P;
        end
      end
      ST_HALVE_P: begin
        if (!status.p_lsb) begin
          cmd.halve_p = 1'b1;
        end else begin
          state_next = ST_LOOP;
        end
      end
      ST_LOOP: begin
        // Halve q while even, subtract when odd, stop when q reaches zero.
        if (status.q_zero) begin
          cmd.finish = 1'b1;
          cmd.sel    = RES_GCD;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else if (!status.q_lsb) begin
          cmd.halve_q = 1'b1;
        end else begin
          cmd.sub = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/beg_datapath.sv */
// Datapath of the binary extended GCD unit: operand, coefficient and result registers.
// Depends on beg_pkg for the beat, command and status types.
module beg_datapath
  import beg_pkg::*;
(
  input  logic      clk,
  input  operands_t operands,
  input  cmd_t      cmd,
  output status_t   status,
  output result_t   result
);

  logic [DATA_W-1:0]        p, q, p0, q0;
  logic signed [COEF_W-1:0] sp, sq, tp, tq;
  logic [SHIFT_W-1:0]       shift;

  logic [DATA_W-1:0]        mag_a, mag_b;
  logic signed [COEF_W-1:0] p0_ext, q0_ext;
  logic signed [COEF_W-1:0] sp_adj, sq_adj, tp_adj, tq_adj;
  logic [DATA_W:0]          q_minus_p, p_minus_q;
  logic                     swap;

  // Magnitude of a two's complement word; the most negative value maps to 2^(DATA_W-1).
  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] x);
    magnitude = x[DATA_W-1] ? (~x + 1'b1) : x;
  endfunction

  assign mag_a  = magnitude(operands.operand_a);
  assign mag_b  = magnitude(operands.operand_b);
  assign p0_ext = signed'({{(COEF_W-DATA_W){1'b0}}, p0});
  assign q0_ext = signed'({{(COEF_W-DATA_W){1'b0}}, q0});

  // Parity corrections keep the coefficient pairs even before halving.
  always_comb begin
    sp_adj = sp;
    sq_adj = sq;
    if (sp[0] | sq[0]) begin
      sp_adj = sp - q0_ext;
      sq_adj = sq + p0_ext;
    end
    tp_adj = tp;
    tq_adj = tq;
    if (tp[0] | tq[0]) begin
      tp_adj = tp - q0_ext;
      tq_adj = tq + p0_ext;
    end
  end

  // The borrow of q - p tells whether the pair must swap before subtracting.
  assign q_minus_p = {1'b0, q} - {1'b0, p};
  assign p_minus_q = {1'b0, p} - {1'b0, q};
  assign swap      = q_minus_p[DATA_W];

  assign status.p_zero = (p == '0);
  assign status.q_zero = (q == '0);
  assign status.p_lsb  = p[0];
  assign status.q_lsb  = q[0];

  // Working registers, updated by one command per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p     <= mag_a;
      q     <= mag_b;
      shift <= '0;
      sp    <= signed'(COEF_W'(1));
      sq    <= '0;
      tp    <= '0;
      tq    <= signed'(COEF_W'(1));
    end
    if (cmd.strip) begin
      p     <= p >> 1;
      q     <= q >> 1;
      shift <= shift + 1'b1;
    end
    if (cmd.latch_base) begin
      p0 <= p;
      q0 <= q;
    end
    if (cmd.halve_p) begin
      p  <= p >> 1;
      sp <= sp_adj >>> 1;
      sq <= sq_adj >>> 1;
    end
    if (cmd.halve_q) begin
      q  <= q >> 1;
      tp <= tp_adj >>> 1;
      tq <= tq_adj >>> 1;
    end
    if (cmd.sub) begin
      if (swap) begin
        p  <= q;
        q  <= p_minus_q[DATA_W-1:0];
        sp <= tp;
        sq <= tq;
        tp <= sp - tp;
        tq <= sq - tq;
      end else begin
        q  <= q_minus_p[DATA_W-1:0];
        tp <= tp - sp;
        tq <= tq - sq;
      end
    end
  end

  // Result register, loaded once per item.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (cmd.sel)
        RES_ZERO_A: begin
          result.coefficient_a <= '0;
          result.gcd_value     <= q;
        end
        RES_ZERO_B: begin
          result.coefficient_a <= signed'((DATA_W+1)'(1));
          result.gcd_value     <= p;
        end
        default: begin
          result.coefficient_a <= sp[DATA_W:0];
          result.gcd_value     <= p << shift;
        end
      endcase
    end
  end

endmodule

/* src/binary_extended_gcd_unit.sv */
// Top level of the binary extended GCD unit.
// Depends on beg_pkg and instantiates beg_ctrl and beg_datapath.
//
// A beat is taken when start is high and busy is low. The unit returns
// gcd(|operand_a|, |operand_b|) and a coefficient s with s*|a| + t*|b| = gcd.
// The result stays on result until the next item finishes, marked by done
// high for a single cycle; the receiver cannot hold it off, and done may
// coincide with the next start. Latency is data dependent. The operands load
// at the accepting edge. After that the unit strips the shared factors of two,
// latches the reduced operands, halves the first operand until it is odd and
// enters the main loop, which halves or subtracts from the second operand
// until it is zero and then finishes. Done is high in the cycle after the
// finishing step. Every halving shrinks the product of the two operands, so
// there are at most about 2*DATA_W halvings and about as many subtractions.
// With a zero operand, the unit finishes without stripping or halving.
module binary_extended_gcd_unit
  import beg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  operands_t operands,
  output logic      busy,
  output logic      done,
  output result_t   result
);

  cmd_t    cmd;
  status_t status;

  beg_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  beg_datapath u_datapath (
    .clk      (clk),
    .operands (operands),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

endmodule
